### src/nst_pkg.sv
package nst_pkg;

	localparam int SlotCount = 8;
	localparam int NameBytes = 16;

	localparam int SlotW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
	localparam int CntW = $clog2(SlotCount + 1);

	localparam int KindW = 2;
	localparam int LenW = 5;
	localparam int NameW = 64;
	localparam int KeyBytes = 2 * NameW / 8;
	localparam int TimeW = 63;
	localparam int LapW = 32;
	localparam int MsW = 54;
	localparam int StatusW = 2;
	localparam int UsedW = 4;

	localparam logic [NameW-1:0] DefaultLow = 64'h0074_6C75_6166_6564;
	localparam int DefaultLen = 7;
	localparam logic [TimeW-1:0] UsMax = {TimeW{1'b1}};
	localparam logic [LapW-1:0] LapMax = {LapW{1'b1}};

	localparam int Divisor = 1000;
	localparam int DivRemW = $clog2(Divisor);
	localparam int DigitBits = 4;
	localparam int DivSteps = (TimeW + DigitBits - 1) / DigitBits;
	localparam int DivWorkW = DivSteps * DigitBits;
	localparam int DivCntW = $clog2(DivSteps);

	typedef enum logic [KindW-1:0] {
		KIND_START  = 2'd0,
		KIND_STOP   = 2'd1,
		KIND_LAP    = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_BAD_NAME = 2'd2
	} status_t;

endpackage

### src/nst_keygen.sv
module nst_keygen (
	input  logic [nst_pkg::NameW-1:0] name_low,
	input  logic [nst_pkg::NameW-1:0] name_high,
	input  logic [nst_pkg::LenW-1:0]  name_length,
	output logic [nst_pkg::NameW-1:0] key_low,
	output logic [nst_pkg::NameW-1:0] key_high,
	output logic                      bad_name
);

	logic [2*nst_pkg::NameW-1:0] raw;
	logic [2*nst_pkg::NameW-1:0] key;
	logic                        empty;

	assign raw = {name_high, name_low};

	// A byte is kept while every byte before it is nonzero and it lies inside the length.
	always_comb begin
		logic       alive;
		logic [7:0] c;
		alive = 1'b1;
		key = '0;
		for (int i = 0; i < nst_pkg::KeyBytes; i++) begin
			c = raw[8*i +: 8];
			alive = alive && (nst_pkg::LenW'(i) < name_length) && (c != 8'h00);
			if (alive) begin
				if (c >= 8'h41 && c <= 8'h5A) begin
					key[8*i +: 8] = c + 8'h20;
				end else begin
					key[8*i +: 8] = c;
				end
			end
		end
	end

	assign empty = (key == '0);

	always_comb begin
		bad_name = (name_length > nst_pkg::LenW'(nst_pkg::NameBytes)) ||
			(empty && (nst_pkg::DefaultLen > nst_pkg::NameBytes));
		if (empty) begin
			key_low = nst_pkg::DefaultLow;
			key_high = '0;
		end else begin
			key_low = key[nst_pkg::NameW-1:0];
			key_high = key[2*nst_pkg::NameW-1:nst_pkg::NameW];
		end
	end

endmodule

### src/nst_div1000.sv
module nst_div1000 (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nst_pkg::TimeW-1:0] dividend,
	output logic                      done,
	output logic [nst_pkg::TimeW-1:0] quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [nst_pkg::DivCntW-1:0]   cnt_q;
	logic [nst_pkg::DivWorkW-1:0]  work_q;
	logic [nst_pkg::DivRemW-1:0]   rem_q;
	logic [nst_pkg::DivWorkW-1:0]  work_nxt;
	logic [nst_pkg::DivRemW-1:0]   rem_nxt;

	// Restoring division, one quotient digit per cycle. Dividend bits leave the top of
	// the work register while quotient bits enter at the bottom.
	always_comb begin
		logic [nst_pkg::DivRemW:0] acc;
		work_nxt = work_q;
		rem_nxt = rem_q;
		for (int k = 0; k < nst_pkg::DigitBits; k++) begin
			acc = {rem_nxt, work_nxt[nst_pkg::DivWorkW-1]};
			work_nxt = {work_nxt[nst_pkg::DivWorkW-2:0], 1'b0};
			if (acc >= (nst_pkg::DivRemW + 1)'(nst_pkg::Divisor)) begin
				acc = acc - (nst_pkg::DivRemW + 1)'(nst_pkg::Divisor);
				work_nxt[0] = 1'b1;
			end
			rem_nxt = acc[nst_pkg::DivRemW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == nst_pkg::DivCntW'(nst_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= nst_pkg::DivWorkW'(dividend);
			rem_q <= '0;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done = done_q;
	assign quotient = work_q[nst_pkg::TimeW-1:0];

endmodule

### src/named_stopwatch_table.sv
// Channel  Handshake            Payload
// in       in_valid / in_ready  kind, name_low, name_high, name_length, now_us
// out      out_valid/out_ready  status, elapsed_ms, is_running, lap_count, slots_used
//
// One command at a time. A bad name goes straight to the result, start scans
// the slots (one cycle per slot through the single name comparator), and stop,
// lap and status may add the divide by 1000 at four quotient bits a cycle.
// in_ready is high only while idle; the result register lets a new command
// start while the previous result is still waiting on out_ready.
// Reset clears the slot occupancy and running flags; no clearing pass is needed.
module named_stopwatch_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [nst_pkg::KindW-1:0]   kind,
	input  logic [nst_pkg::NameW-1:0]   name_low,
	input  logic [nst_pkg::NameW-1:0]   name_high,
	input  logic [nst_pkg::LenW-1:0]    name_length,
	input  logic [nst_pkg::TimeW-1:0]   now_us,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [nst_pkg::StatusW-1:0] status,
	output logic [nst_pkg::MsW-1:0]     elapsed_ms,
	output logic                        is_running,
	output logic [nst_pkg::LapW-1:0]    lap_count,
	output logic [nst_pkg::UsedW-1:0]   slots_used
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCAN  = 6'b000010,
		S_DIFF  = 6'b000100,
		S_TOTAL = 6'b001000,
		S_DIV   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;

	// Slot table.
	logic [nst_pkg::SlotCount-1:0] in_use_q;
	logic [nst_pkg::SlotCount-1:0] run_q;
	logic [nst_pkg::NameW-1:0]     name_lo_q  [nst_pkg::SlotCount];
	logic [nst_pkg::NameW-1:0]     name_hi_q  [nst_pkg::SlotCount];
	logic [nst_pkg::TimeW-1:0]     start_q    [nst_pkg::SlotCount];
	logic [nst_pkg::TimeW-1:0]     elapsed_q  [nst_pkg::SlotCount];
	logic [nst_pkg::LapW-1:0]      laps_q     [nst_pkg::SlotCount];
	logic [nst_pkg::CntW-1:0]      used_q;

	// Command context.
	nst_pkg::kind_t              kind_q;
	logic [nst_pkg::NameW-1:0]   key_lo_q;
	logic [nst_pkg::NameW-1:0]   key_hi_q;
	logic [nst_pkg::TimeW-1:0]   now_q;
	logic [nst_pkg::SlotW-1:0]   scan_q;
	logic                        found_q;
	logic [nst_pkg::SlotW-1:0]   found_idx_q;
	logic                        free_q;
	logic [nst_pkg::SlotW-1:0]   free_idx_q;
	logic                        ge_q;
	logic [nst_pkg::TimeW-1:0]   d_q;

	// Pending result.
	nst_pkg::status_t            res_status_q;
	logic                        res_run_q;
	logic [nst_pkg::LapW-1:0]    res_laps_q;
	logic                        res_div_q;

	// Output register.
	logic                        out_valid_q;
	logic [nst_pkg::StatusW-1:0] status_q;
	logic [nst_pkg::MsW-1:0]     elapsed_ms_q;
	logic                        is_running_q;
	logic [nst_pkg::LapW-1:0]    lap_count_q;
	logic [nst_pkg::UsedW-1:0]   slots_used_q;

	logic [nst_pkg::NameW-1:0]   gen_lo;
	logic [nst_pkg::NameW-1:0]   gen_hi;
	logic                        gen_bad;
	logic                        accept;
	logic [nst_pkg::SlotW-1:0]   sel_idx;
	logic [nst_pkg::SlotW-1:0]   rd_idx;
	logic                        rd_hit;
	logic                        take_slot;
	logic                        load_out;
	logic [nst_pkg::TimeW-1:0]   rd_start;
	logic [nst_pkg::TimeW-1:0]   rd_elapsed;
	logic                        now_ge;
	logic [nst_pkg::TimeW:0]     sum_up;
	logic [nst_pkg::TimeW:0]     sum_dn;
	logic [nst_pkg::TimeW-1:0]   total;
	logic                        div_start;
	logic                        div_done;
	logic [nst_pkg::TimeW-1:0]   div_quot;

	nst_keygen u_keygen (
		.name_low    (name_low),
		.name_high   (name_high),
		.name_length (name_length),
		.key_low     (gen_lo),
		.key_high    (gen_hi),
		.bad_name    (gen_bad)
	);

	nst_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;

	// A start reuses its own slot if the name exists, otherwise the lowest free one.
	assign sel_idx = found_q ? found_idx_q : free_idx_q;
	assign rd_idx = (state_q == S_SCAN) ? scan_q : sel_idx;
	assign rd_hit = in_use_q[rd_idx] && (name_lo_q[rd_idx] == key_lo_q) &&
		(name_hi_q[rd_idx] == key_hi_q);
	assign rd_start = start_q[rd_idx];
	assign rd_elapsed = elapsed_q[rd_idx];

	assign take_slot = (state_q == S_DIFF) && (kind_q == nst_pkg::KIND_START) &&
		(found_q || free_q);

	assign now_ge = (now_q >= rd_start);

	// Live total: a running slot adds the time since its start, clamped to the
	// range of a nonnegative 63-bit count.
	assign sum_up = {1'b0, rd_elapsed} + {1'b0, d_q};
	assign sum_dn = {1'b0, rd_elapsed} - {1'b0, d_q};
	always_comb begin
		if (!run_q[rd_idx]) begin
			total = rd_elapsed;
		end else if (ge_q) begin
			total = sum_up[nst_pkg::TimeW] ? nst_pkg::UsMax : sum_up[nst_pkg::TimeW-1:0];
		end else begin
			total = sum_dn[nst_pkg::TimeW] ? '0 : sum_dn[nst_pkg::TimeW-1:0];
		end
	end

	assign div_start = (state_q == S_TOTAL);
	assign load_out = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			in_use_q <= '0;
			run_q <= '0;
			used_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (take_slot) begin
				in_use_q[sel_idx] <= 1'b1;
				run_q[sel_idx] <= 1'b1;
				if (!found_q) begin
					used_q <= used_q + 1'b1;
				end
			end
			if ((state_q == S_TOTAL) && (kind_q == nst_pkg::KIND_STOP)) begin
				run_q[rd_idx] <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= gen_bad ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_q == nst_pkg::SlotW'(nst_pkg::SlotCount - 1)) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					if (kind_q == nst_pkg::KIND_START || !found_q) begin
						state_q <= S_FIN;
					end else if (kind_q != nst_pkg::KIND_STATUS && !run_q[rd_idx]) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_TOTAL;
					end
				end
				S_TOTAL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command context and slot payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= nst_pkg::kind_t'(kind);
			key_lo_q <= gen_lo;
			key_hi_q <= gen_hi;
			now_q <= now_us;
			scan_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			found_idx_q <= '0;
			free_idx_q <= '0;
			res_status_q <= gen_bad ? nst_pkg::ST_BAD_NAME : nst_pkg::ST_OK;
			res_run_q <= 1'b0;
			res_laps_q <= '0;
			res_div_q <= 1'b0;
		end

		if (state_q == S_SCAN) begin
			scan_q <= scan_q + 1'b1;
			if (rd_hit && !found_q) begin
				found_q <= 1'b1;
				found_idx_q <= scan_q;
			end
			if (!in_use_q[rd_idx] && !free_q) begin
				free_q <= 1'b1;
				free_idx_q <= scan_q;
			end
		end

		if (state_q == S_DIFF) begin
			ge_q <= now_ge;
			d_q <= now_ge ? (now_q - rd_start) : (rd_start - now_q);
			if (kind_q == nst_pkg::KIND_START) begin
				if (!take_slot) begin
					res_status_q <= nst_pkg::ST_MISS;
				end
			end else if (!found_q) begin
				res_status_q <= nst_pkg::ST_MISS;
			end else if (kind_q != nst_pkg::KIND_STATUS && !run_q[rd_idx]) begin
				res_status_q <= nst_pkg::ST_MISS;
			end
		end

		if (take_slot) begin
			name_lo_q[sel_idx] <= key_lo_q;
			name_hi_q[sel_idx] <= key_hi_q;
			start_q[sel_idx] <= now_q;
			elapsed_q[sel_idx] <= '0;
			laps_q[sel_idx] <= '0;
		end

		if (state_q == S_TOTAL) begin
			res_div_q <= 1'b1;
			case (kind_q)
				nst_pkg::KIND_STOP: begin
					elapsed_q[rd_idx] <= total;
				end
				nst_pkg::KIND_LAP: begin
					if (laps_q[rd_idx] != nst_pkg::LapMax) begin
						laps_q[rd_idx] <= laps_q[rd_idx] + 1'b1;
					end
				end
				nst_pkg::KIND_STATUS: begin
					res_run_q <= run_q[rd_idx];
					res_laps_q <= laps_q[rd_idx];
				end
				default: begin
				end
			endcase
		end

		if (load_out) begin
			status_q <= res_status_q;
			elapsed_ms_q <= res_div_q ? div_quot[nst_pkg::MsW-1:0] : '0;
			is_running_q <= res_run_q;
			lap_count_q <= res_laps_q;
			slots_used_q <= nst_pkg::UsedW'(used_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign elapsed_ms = elapsed_ms_q;
	assign is_running = is_running_q;
	assign lap_count = lap_count_q;
	assign slots_used = slots_used_q;

	// The occupancy counter tracks the in-use flags.
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_q == nst_pkg::CntW'($countones(in_use_q)))
		else $error("slot count disagrees with in-use flags");

	// Only an occupied slot can be running.
	a_run_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q & ~in_use_q) == '0)
		else $error("running flag set on a free slot");

	// The divider reports completion only while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside its wait state");

	// An accepted transaction either scans the table or goes straight to the result.
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_SCAN || state_q == S_FIN))
		else $error("unexpected state after accepting a transaction");

endmodule
